@@ hdl/mexp_pkg.sv @@
`default_nettype none
package mexp_pkg;

   localparam int WIDTH = 64;
   localparam int FIELD_WIDTH = 64;
   localparam int COUNT_WIDTH = $clog2(WIDTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MULT,
      ST_SQUARE,
      ST_FINISH
   } state_type;

   // Borrow and carry chains that ripple from cell to cell.
   typedef struct packed {
      logic b1;
      logic c;
      logic b2;
   } chain_type;

   // Select decisions broadcast back to every cell.
   typedef struct packed {
      logic sub1;
      logic sub2;
   } select_type;

   typedef struct packed {
      logic start;
      logic add_mode;
   } ctrl_type;

endpackage
`default_nettype wire

@@ hdl/mexp_cell.sv @@
`default_nettype none
module mexp_cell
   import mexp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       clear,
   input  wire logic       step,
   input  wire logic       d_in,
   input  wire logic       m_bit,
   input  wire logic       x_bit,
   input  wire logic       add_en,
   input  wire select_type sel,
   input  wire chain_type  chain_in,
   output chain_type       chain_out,
   output logic            acc_out
);

   logic acc_ff;
   logic acc_in;
   logic t1;
   logic r;
   logic xa;
   logic s;
   logic u;

   // The doubled value arrives from the lower neighbor; subtract m, add x, subtract m.
   always_comb begin
      t1 = d_in ^ m_bit ^ chain_in.b1;
      chain_out.b1 = (~d_in & m_bit) | (~(d_in ^ m_bit) & chain_in.b1);
      r = sel.sub1 ? t1 : d_in;
      xa = x_bit & add_en;
      s = r ^ xa ^ chain_in.c;
      chain_out.c = (r & xa) | (chain_in.c & (r ^ xa));
      u = s ^ m_bit ^ chain_in.b2;
      chain_out.b2 = (~s & m_bit) | (~(s ^ m_bit) & chain_in.b2);
      acc_in = sel.sub2 ? u : s;
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         acc_ff <= 1'b0;
      end else if (step) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule
`default_nettype wire

@@ hdl/mexp_mulmod.sv @@
`default_nettype none
module mexp_mulmod
   import mexp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ctrl_type         ctrl,
   input  wire logic [WIDTH-1:0] x,
   input  wire logic [WIDTH-1:0] y,
   input  wire logic [WIDTH-1:0] m,
   output logic                  done,
   output logic [WIDTH-1:0]      result
);

   logic                   running_ff;
   logic                   running_in;
   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [COUNT_WIDTH-1:0] cnt_in;
   logic [WIDTH-1:0]       x_ff;
   logic [WIDTH-1:0]       y_ff;
   logic [WIDTH-1:0]       m_ff;
   logic                   add_mode_ff;
   logic                   step;
   logic                   in_bit;
   logic                   add_en;
   logic [WIDTH-1:0]       acc;
   chain_type              chain [WIDTH+1];
   select_type             sel;

   assign step = running_ff && (cnt_ff != '0);
   assign done = running_ff && (cnt_ff == '0);

   // In reduce mode the y word is shifted in as a dividend; otherwise it is the multiplier.
   assign in_bit = add_mode_ff ? 1'b0 : y_ff[WIDTH-1];
   assign add_en = add_mode_ff & y_ff[WIDTH-1];

   assign chain[0] = '0;
   assign sel.sub1 = acc[WIDTH-1] | ~chain[WIDTH].b1;
   assign sel.sub2 = chain[WIDTH].c | ~chain[WIDTH].b2;

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      mexp_cell u_cell (
         .clock     (clock),
         .clear     (ctrl.start),
         .step      (step),
         .d_in      ((i == 0) ? in_bit : acc[(i == 0) ? 0 : i - 1]),
         .m_bit     (m_ff[i]),
         .x_bit     (x_ff[i]),
         .add_en    (add_en),
         .sel       (sel),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .acc_out   (acc[i])
      );
   end

   always_comb begin
      running_in = running_ff;
      cnt_in = cnt_ff;
      if (ctrl.start) begin
         running_in = 1'b1;
         cnt_in = COUNT_WIDTH'(WIDTH);
      end else if (step) begin
         cnt_in = cnt_ff - COUNT_WIDTH'(1);
      end else if (done) begin
         running_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         running_ff <= running_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         x_ff <= x;
         y_ff <= y;
         m_ff <= m;
         add_mode_ff <= ctrl.add_mode;
      end else if (step) begin
         y_ff <= {y_ff[WIDTH-2:0], 1'b0};
      end
   end

   assign result = acc;

`ifndef NO_ASSERTIONS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.start && running_ff && !done))
      else $error("multiplier restarted while busy");
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      done |-> (result < m_ff))
      else $error("multiplier result not reduced");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      (done && !ctrl.start) |=> !running_ff)
      else $error("multiplier stayed busy after done");
`endif

endmodule
`default_nettype wire

@@ hdl/modular_exponentiation.sv @@
`default_nettype none
// Computes base^exponent mod modulus on unsigned 64-bit operands by right-to-left
// square-and-multiply. One request is worked on at a time; req_stall is high while it
// runs. A row of one-bit cells forms a bit-serial modular multiplier; a request first
// reduces the base, then takes a square for each exponent bit up to the highest set bit
// and a multiply for each set bit. A zero modulus returns 0 with zero_modulus_error set,
// and a zero exponent returns 1, both without using the multiplier. The result waits in
// an output register while the next request is taken.
module modular_exponentiation
   import mexp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [FIELD_WIDTH-1:0] req_base,
   input  wire logic [FIELD_WIDTH-1:0] req_exponent,
   input  wire logic [FIELD_WIDTH-1:0] req_modulus,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [FIELD_WIDTH-1:0]      rsp_power_result,
   output logic                        rsp_zero_modulus_error
);

   state_type        state_ff;
   state_type        state_in;
   logic [WIDTH-1:0] acc_ff;
   logic [WIDTH-1:0] acc_in;
   logic [WIDTH-1:0] pw_ff;
   logic [WIDTH-1:0] pw_in;
   logic [WIDTH-1:0] e_ff;
   logic [WIDTH-1:0] e_in;
   logic [WIDTH-1:0] m_ff;
   logic [WIDTH-1:0] m_in;
   logic             err_ff;
   logic             err_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [WIDTH-1:0] rsp_result_ff;
   logic             rsp_err_ff;
   logic             load_rsp;
   ctrl_type         ctrl;
   logic [WIDTH-1:0] mul_x;
   logic [WIDTH-1:0] mul_y;
   logic [WIDTH-1:0] mul_m;
   logic             mul_done;
   logic [WIDTH-1:0] mul_result;
   logic [WIDTH-1:0] e_next;
   logic [WIDTH-1:0] req_b;
   logic [WIDTH-1:0] req_e;
   logic [WIDTH-1:0] req_m;

   assign req_b = req_base[WIDTH-1:0];
   assign req_e = req_exponent[WIDTH-1:0];
   assign req_m = req_modulus[WIDTH-1:0];
   assign req_stall = (state_ff != ST_IDLE);
   assign e_next = e_ff >> 1;

   mexp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .x      (mul_x),
      .y      (mul_y),
      .m      (mul_m),
      .done   (mul_done),
      .result (mul_result)
   );

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      pw_in = pw_ff;
      e_in = e_ff;
      m_in = m_ff;
      err_in = err_ff;
      ctrl = '0;
      mul_x = '0;
      mul_y = '0;
      mul_m = m_ff;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               e_in = req_e;
               m_in = req_m;
               err_in = 1'b0;
               if (req_m == '0) begin
                  acc_in = '0;
                  err_in = 1'b1;
                  state_in = ST_FINISH;
               end else if (req_e == '0) begin
                  acc_in = WIDTH'(1);
                  state_in = ST_FINISH;
               end else begin
                  // Reduce the base by shifting it in through the multiplier row.
                  ctrl.start = 1'b1;
                  ctrl.add_mode = 1'b0;
                  mul_y = req_b;
                  mul_m = req_m;
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_done) begin
               pw_in = mul_result;
               acc_in = (m_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
               ctrl.start = 1'b1;
               ctrl.add_mode = 1'b1;
               mul_x = mul_result;
               if (e_ff[0]) begin
                  mul_y = acc_in;
                  state_in = ST_MULT;
               end else begin
                  mul_y = mul_result;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               acc_in = mul_result;
               ctrl.start = 1'b1;
               ctrl.add_mode = 1'b1;
               mul_x = pw_ff;
               mul_y = pw_ff;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_done) begin
               pw_in = mul_result;
               e_in = e_next;
               if (e_next == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  ctrl.start = 1'b1;
                  ctrl.add_mode = 1'b1;
                  mul_x = mul_result;
                  if (e_next[0]) begin
                     mul_y = acc_ff;
                     state_in = ST_MULT;
                  end else begin
                     mul_y = mul_result;
                     state_in = ST_SQUARE;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      pw_ff <= pw_in;
      e_ff <= e_in;
      m_ff <= m_in;
      err_ff <= err_in;
      if (load_rsp) begin
         rsp_result_ff <= acc_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power_result = FIELD_WIDTH'(rsp_result_ff);
   assign rsp_zero_modulus_error = rsp_err_ff;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_modulus_error) |-> (rsp_power_result == '0))
      else $error("error response with nonzero result");
   a_done_in_work: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_REDUCE || state_ff == ST_MULT || state_ff == ST_SQUARE))
      else $error("multiplier finished outside a working state");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load_rsp)
      else $error("pending response overwritten");
`endif

endmodule
`default_nettype wire

@@ tb/sv/modular_exponentiation_tb.sv @@
`timescale 1ns / 1ps
module modular_exponentiation_tb;
   import mexp_pkg::*;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] power_result;
      logic                   zero_modulus_error;
   } power_type;

   typedef struct {
      logic [FIELD_WIDTH-1:0] base;
      logic [FIELD_WIDTH-1:0] exponent;
      logic [FIELD_WIDTH-1:0] modulus;
      logic                   has_known;
      power_type              known;
   } vector_type;

   localparam logic [FIELD_WIDTH-1:0] ALL_ONES = '1;
   localparam int RANDOM_COUNT = 82;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [FIELD_WIDTH-1:0] req_base = '0;
   logic [FIELD_WIDTH-1:0] req_exponent = '0;
   logic [FIELD_WIDTH-1:0] req_modulus = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [FIELD_WIDTH-1:0] rsp_power_result;
   logic                   rsp_zero_modulus_error;

   power_type  pending_powers[$];
   vector_type vectors[$];
   int         failures = 0;
   bit         steady = 1'b0;

   modular_exponentiation DUT (.*);

   always #5 clock = ~clock;

   // Shift-and-add modular product, one multiplier bit at a time from the top.
   function automatic logic [WIDTH-1:0] product_mod(input logic [WIDTH-1:0] x,
         input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] m);
      logic [WIDTH:0] sum;
      logic [WIDTH:0] wide_m;
      logic [WIDTH:0] wide_x;
      sum = '0;
      wide_m = {1'b0, m};
      wide_x = {1'b0, x};
      for (int i = WIDTH - 1; i >= 0; i--) begin
         sum = sum << 1;
         if (sum >= wide_m) sum = sum - wide_m;
         if (y[i]) begin
            sum = sum + wide_x;
            if (sum >= wide_m) sum = sum - wide_m;
         end
      end
      return sum[WIDTH-1:0];
   endfunction

   function automatic power_type power_mod(input logic [FIELD_WIDTH-1:0] b,
         input logic [FIELD_WIDTH-1:0] e, input logic [FIELD_WIDTH-1:0] m);
      power_type      r;
      logic [WIDTH-1:0] acc;
      logic [WIDTH-1:0] run;
      r = '0;
      if (m[WIDTH-1:0] == '0) begin
         r.zero_modulus_error = 1'b1;
      end else if (e[WIDTH-1:0] == '0) begin
         r.power_result = FIELD_WIDTH'(1);
      end else begin
         acc = (m[WIDTH-1:0] == WIDTH'(1)) ? '0 : WIDTH'(1);
         run = b[WIDTH-1:0] % m[WIDTH-1:0];
         for (int i = 0; i < WIDTH; i++) begin
            if (e[i]) acc = product_mod(acc, run, m[WIDTH-1:0]);
            run = product_mod(run, run, m[WIDTH-1:0]);
         end
         r.power_result = FIELD_WIDTH'(acc);
      end
      return r;
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // Half of the operands are masked or shifted shorter to keep runs fast; the rest are full width.
   function automatic logic [FIELD_WIDTH-1:0] random_field();
      logic [FIELD_WIDTH-1:0] w;
      w = random_word();
      case ($urandom_range(0, 5))
         0: w = w & 64'hFF;
         1: w = w & 64'hFFFF;
         2: w = w >> $urandom_range(0, 63);
         default: ;
      endcase
      return w;
   endfunction

   function automatic vector_type row(input logic [FIELD_WIDTH-1:0] b,
         input logic [FIELD_WIDTH-1:0] e, input logic [FIELD_WIDTH-1:0] m);
      vector_type v;
      v.base = b;
      v.exponent = e;
      v.modulus = m;
      v.has_known = 1'b0;
      v.known = '0;
      return v;
   endfunction

   function automatic vector_type known_row(input logic [FIELD_WIDTH-1:0] b,
         input logic [FIELD_WIDTH-1:0] e, input logic [FIELD_WIDTH-1:0] m,
         input logic [FIELD_WIDTH-1:0] p, input logic z);
      vector_type v;
      v = row(b, e, m);
      v.has_known = 1'b1;
      v.known.power_result = p;
      v.known.zero_modulus_error = z;
      return v;
   endfunction

   // Valid stays high from one request to the next unless the sender idles.
   task automatic send_request(input vector_type v);
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base <= v.base;
      req_exponent <= v.exponent;
      req_modulus <= v.modulus;
      pending_powers.push_back(v.has_known ? v.known :
                               power_mod(v.base, v.exponent, v.modulus));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_stall <= !steady && ($urandom_range(0, 99) < 38);
   end

   always @(posedge clock) begin
      power_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_powers.size() == 0) begin
            $error("result with no request waiting");
            failures++;
         end else begin
            want = pending_powers.pop_front();
            if (rsp_power_result !== want.power_result) begin
               $error("power_result expected %h actual %h", want.power_result,
                      rsp_power_result);
               failures++;
            end
            if (rsp_zero_modulus_error !== want.zero_modulus_error) begin
               $error("zero_modulus_error expected %b actual %b",
                      want.zero_modulus_error, rsp_zero_modulus_error);
               failures++;
            end
         end
      end
   end

   initial begin
      vectors.push_back(known_row(5, 3, 0, 0, 1'b1));
      vectors.push_back(known_row(5, 0, 0, 0, 1'b1));
      vectors.push_back(known_row(ALL_ONES, ALL_ONES, 0, 0, 1'b1));
      vectors.push_back(known_row(7, 0, 1, 1, 1'b0));
      vectors.push_back(known_row(ALL_ONES, 0, ALL_ONES, 1, 1'b0));
      vectors.push_back(known_row(0, 0, 13, 1, 1'b0));
      vectors.push_back(known_row(0, 5, 13, 0, 1'b0));
      vectors.push_back(known_row(9, 5, 1, 0, 1'b0));
      vectors.push_back(known_row(ALL_ONES, 1, ALL_ONES, 0, 1'b0));
      vectors.push_back(known_row(2, 10, 1000, 24, 1'b0));
      vectors.push_back(known_row(3, 4, 5, 1, 1'b0));
      vectors.push_back(row(ALL_ONES, ALL_ONES, ALL_ONES - 1));
      vectors.push_back(row(ALL_ONES - 1, ALL_ONES, ALL_ONES));
      vectors.push_back(row(64'h8000_0000_0000_0000, ALL_ONES, 64'hFFFF_FFFF_FFFF_FFC5));
      vectors.push_back(row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                            64'hAAAA_AAAA_AAAA_AAAB));
      vectors.push_back(row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                            64'h8000_0000_0000_0001));
      vectors.push_back(row(123, 64'h8000_0000_0000_0000, 1_000_000_007));
      vectors.push_back(row(ALL_ONES, 2, 3));
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         vectors.push_back(row(random_field(), random_field(),
                               ($urandom_range(0, 19) == 0) ? '0 : random_field()));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (vectors[i]) begin
         steady = (i >= 40 && i < 55);
         send_request(vectors[i]);
         // Let the block drain completely once, mid-run.
         if (i == 30) begin
            req_valid <= 1'b0;
            wait (pending_powers.size() == 0);
         end
      end
      req_valid <= 1'b0;
      steady = 1'b0;
      wait (pending_powers.size() == 0);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ modular_exponentiation.f @@
hdl/mexp_pkg.sv
hdl/mexp_cell.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
